// File: rtl/core/lcomp_pkg.sv
// Shared constants for the layer line compositor.
package lcomp_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DISPLAY_MODE     = 2'd0;
  localparam logic [1:0] REG_INVERT_PRIORITY  = 2'd1;
  localparam logic [1:0] REG_BYTE_SHIFT       = 2'd2;
  localparam logic [1:0] REG_BACKGROUND_COLOR = 2'd3;

  // Request kinds
  localparam logic [1:0] KIND_PALETTE  = 2'd0;
  localparam logic [1:0] KIND_UNDER    = 2'd1;
  localparam logic [1:0] KIND_DATA     = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // Display modes
  localparam logic [1:0] MODE_BLANK  = 2'd0;
  localparam logic [1:0] MODE_PACKED = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  // Defaults
  localparam int LINE_WIDTH_DEF    = 320;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int GROUP_PIXELS_DEF  = 4;

  localparam logic [15:0] OVERLAY_FLAG = 16'h8000;
  localparam logic [5:0]  BG_MASK      = 6'h3f;

endpackage

// File: rtl/core/layer_line_compositor.sv
// Layer line compositor: palette, background line buffer and pixel sequencer.
// A palette or background write request is written straight into its memory. A line
// data word is accepted and then decoded pixel by pixel: a palette and background
// memory read, then the compositing compare; each output group is held until its
// result has been taken. The shared read-and-compare step handles one pixel at a
// time; in_stall is high until the last group of the word has been taken. Pixels
// past the line width are dropped; a word whose pixels are all dropped gives no
// result.
module layer_line_compositor #(
  parameter int LINE_WIDTH    = lcomp_pkg::LINE_WIDTH_DEF,
  parameter int PALETTE_DEPTH = lcomp_pkg::PALETTE_DEPTH_DEF,
  parameter int GROUP_PIXELS  = lcomp_pkg::GROUP_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [8:0]  index,
  input  logic [15:0] value,
  input  logic [7:0]  under_pixel,
  input  logic        line_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_a,
  output logic [15:0] pixel_b,
  output logic [15:0] pixel_c,
  output logic [15:0] pixel_d,
  output logic [2:0]  pixel_count,
  output logic [8:0]  first_position,
  output logic        line_end,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int GRP   = (GROUP_PIXELS < 1) ? 1 : ((GROUP_PIXELS > 4) ? 4 : GROUP_PIXELS);
  localparam int POS_W = $clog2(LINE_WIDTH + 1);
  localparam int UA_W  = $clog2(LINE_WIDTH);
  localparam int PA_W  = $clog2(PALETTE_DEPTH);
  localparam logic [POS_W-1:0] LW_POS = POS_W'(LINE_WIDTH);
  localparam logic [2:0]       GRP_C  = 3'(GRP);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_MIX   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // Configuration registers
  logic [1:0] display_mode;
  logic       invert_priority;
  logic       byte_shift;
  logic [5:0] background_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode     <= lcomp_pkg::MODE_BLANK;
      invert_priority  <= 1'b0;
      byte_shift       <= 1'b0;
      background_color <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcomp_pkg::REG_DISPLAY_MODE:     display_mode     <= cfg_data[1:0];
        lcomp_pkg::REG_INVERT_PRIORITY:  invert_priority  <= cfg_data[0];
        lcomp_pkg::REG_BYTE_SHIFT:       byte_shift       <= cfg_data[0];
        lcomp_pkg::REG_BACKGROUND_COLOR: background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state
  logic [1:0]       state;
  logic [POS_W-1:0] position;
  logic             first_word_seen;
  logic [8:0]       remaining;
  logic             hi_byte;
  logic [2:0]       cnt;
  logic [15:0]      value_q;
  logic [15:0]      slot [4];
  logic [15:0]      pal_q;
  logic [7:0]       und_q;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Memories with registered reads
  logic [15:0] palette    [PALETTE_DEPTH];
  logic [7:0]  under_line [LINE_WIDTH];
  logic [PA_W-1:0] pal_addr;
  assign pal_addr = PA_W'(hi_byte ? value_q[15:8] : value_q[7:0]);

  always_ff @(posedge clk) begin
    if (accept && kind == lcomp_pkg::KIND_PALETTE &&
        {1'b0, index} < 10'(PALETTE_DEPTH))
      palette[index[PA_W-1:0]] <= value;
    if (accept && kind == lcomp_pkg::KIND_UNDER && {1'b0, index} < 10'(LINE_WIDTH))
      under_line[UA_W'(index)] <= under_pixel;
    pal_q <= palette[pal_addr];
    und_q <= under_line[position[UA_W-1:0]];
  end

  // Compositing of the current pixel
  logic [15:0] colour;
  logic        over;
  logic [15:0] pix;
  logic [8:0]  rem_n;
  logic [POS_W-1:0] pos_n;
  logic        more;

  always_comb begin
    colour = (display_mode == lcomp_pkg::MODE_DIRECT) ? value_q : pal_q;
    over   = ((und_q[5:0] & lcomp_pkg::BG_MASK) == background_color) ||
             (colour[15] ^ invert_priority);
    pix    = over ? (lcomp_pkg::OVERLAY_FLAG | {1'b0, colour[14:0]}) : {8'd0, und_q};
    rem_n  = remaining - 9'd1;
    pos_n  = position + POS_W'(1);
    more   = (rem_n != 9'd0) && (pos_n < LW_POS);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      position        <= '0;
      first_word_seen <= 1'b0;
      out_valid       <= 1'b0;
      cnt             <= 3'd0;
      remaining       <= 9'd0;
      hi_byte         <= 1'b0;
      last            <= 1'b0;
      line_end        <= 1'b0;
      first_position  <= 9'd0;
      for (int i = 0; i < 4; i++) slot[i] <= 16'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && kind == lcomp_pkg::KIND_DATA &&
              display_mode != lcomp_pkg::MODE_BLANK) begin
            value_q         <= value;
            first_word_seen <= 1'b1;
            cnt             <= 3'd0;
            for (int i = 0; i < 4; i++) slot[i] <= 16'd0;
            if (line_start) position <= '0;
            case (display_mode)
              lcomp_pkg::MODE_PACKED: begin
                hi_byte   <= !((line_start || !first_word_seen) && byte_shift);
                remaining <= ((line_start || !first_word_seen) && byte_shift) ? 9'd1 : 9'd2;
              end
              lcomp_pkg::MODE_RUN: begin
                hi_byte   <= 1'b0;
                remaining <= {1'b0, value[15:8]} + 9'd1;
              end
              default: begin
                hi_byte   <= 1'b0;
                remaining <= 9'd1;
              end
            endcase
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // Only reached with nothing pending when the line is already full
          if (remaining == 9'd0 || position >= LW_POS) state <= S_IDLE;
          else state <= S_MIX;
        end
        S_MIX: begin
          slot[cnt[1:0]] <= pix;
          if (cnt == 3'd0) first_position <= 9'(position);
          cnt       <= cnt + 3'd1;
          position  <= pos_n;
          remaining <= rem_n;
          hi_byte   <= 1'b0;
          if (cnt + 3'd1 == GRP_C || !more) begin
            out_valid <= 1'b1;
            last      <= !more;
            line_end  <= (pos_n == LW_POS);
            state     <= S_EMIT;
          end else begin
            state <= S_FETCH;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            cnt       <= 3'd0;
            for (int i = 0; i < 4; i++) slot[i] <= 16'd0;
            state <= last ? S_IDLE : S_FETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pixel_a     = slot[0];
  assign pixel_b     = slot[1];
  assign pixel_c     = slot[2];
  assign pixel_d     = slot[3];
  assign pixel_count = cnt;

`ifndef NO_ASSERTIONS
  // A result is only offered while the sequencer holds it
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EMIT)) else $error("result outside emit");
  // Groups are never empty nor larger than the group size
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_count != 3'd0 && pixel_count <= GRP_C))
    else $error("bad group count");
  // Line position never runs past the line width
  a_pos: assert property (@(posedge clk) disable iff (rst)
    position <= LW_POS) else $error("position overflow");
  // New requests are refused while a group is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while busy");
`endif

endmodule
